>>> hdl/iasmd_pkg.sv
// Shared types and constants for the iterative add/sub/mul/div unit.
// No dependencies; imported by every module of the unit.
package iasmd_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    typedef logic [DATA_WIDTH-1:0] word_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    // Last step index: multiply walks every multiplier bit, divide every
    // quotient bit below the sign bit.
    localparam cnt_t MUL_LAST = cnt_t'(DATA_WIDTH - 1);
    localparam cnt_t DIV_LAST = cnt_t'(DATA_WIDTH - 2);

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic step;
    } dp_ctrl_t;

    // Status from datapath to controller
    typedef struct packed {
        cmd_t cmd;
        logic err;
    } dp_stat_t;

endpackage

>>> hdl/iasmd_ctrl.sv
// Controller state machine of the add/sub/mul/div unit: sequences load,
// iteration steps and the result strobe. Depends on iasmd_pkg.
module iasmd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  iasmd_pkg::dp_stat_t stat,
    output iasmd_pkg::dp_ctrl_t ctrl,
    output logic              busy,
    output logic              done
);
    import iasmd_pkg::*;

    state_t state_reg, state_next;
    cnt_t   cnt_reg, cnt_next;
    cnt_t   last;
    logic   quick;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign last  = (stat.cmd == CMD_MUL) ? MUL_LAST : DIV_LAST;
    // Add, subtract and a refused divide need no iteration
    assign quick = (stat.cmd == CMD_ADD) || (stat.cmd == CMD_SUB) || stat.err;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctrl       = '0;
        done       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (quick)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ctrl.step = 1'b1;
                    cnt_next  = cnt_reg + cnt_t'(1);
                    if (cnt_reg == last)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

>>> hdl/iasmd_datapath.sv
// Datapath of the add/sub/mul/div unit: operand registers, shift-add
// multiplier and restoring divider sharing one accumulator. Depends on iasmd_pkg.
module iasmd_datapath (
    input  logic                 clk,
    input  iasmd_pkg::cmd_t      command,
    input  iasmd_pkg::word_t     operand_a,
    input  iasmd_pkg::word_t     operand_b,
    input  iasmd_pkg::dp_ctrl_t  ctrl,
    output iasmd_pkg::dp_stat_t  stat,
    output iasmd_pkg::word_t     result,
    output logic                 err
);
    import iasmd_pkg::*;

    cmd_t  cmd_reg;
    word_t a_reg;     // multiplier (shifts right) or dividend (shifts left)
    word_t b_reg;     // multiplicand (shifts left) or divisor (holds)
    word_t acc_reg;   // sum, difference, product or partial remainder
    word_t q_reg;
    word_t mask_reg;  // divisor bits that put a set quotient bit out of range
    logic  err_reg;

    word_t trial;
    word_t diff;
    logic  ge;
    logic  too_big;

    // Bring down the next dividend bit and try the subtract
    assign trial   = {acc_reg[DATA_WIDTH-2:0], a_reg[DATA_WIDTH-2]};
    assign diff    = trial - b_reg;
    assign ge      = (trial >= b_reg);
    assign too_big = |(b_reg & mask_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg  <= command;
            a_reg    <= operand_a;
            b_reg    <= operand_b;
            q_reg    <= '0;
            mask_reg <= '1;
            case (command)
                CMD_ADD: acc_reg <= operand_a + operand_b;
                CMD_SUB: acc_reg <= operand_a + (~operand_b + word_t'(1));
                default: acc_reg <= '0;
            endcase
            err_reg <= (command == CMD_DIV) &&
                       ((operand_b == '0) || operand_a[DATA_WIDTH-1] ||
                        operand_b[DATA_WIDTH-1]);
        end
        else if (ctrl.step)
        begin
            if (cmd_reg == CMD_MUL)
            begin
                if (a_reg[0])
                begin
                    acc_reg <= acc_reg + b_reg;
                end
                a_reg <= a_reg >> 1;
                b_reg <= b_reg << 1;
            end
            else
            begin
                acc_reg  <= ge ? diff : trial;
                q_reg    <= {q_reg[DATA_WIDTH-2:0], ge};
                a_reg    <= a_reg << 1;
                mask_reg <= mask_reg << 1;
                // A quotient bit this high means the divisor shift overflows
                if (ge && too_big)
                begin
                    err_reg <= 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        case (cmd_reg)
            CMD_DIV: result = err_reg ? '0 : q_reg;
            default: result = acc_reg;
        endcase
    end

    assign err       = err_reg;
    assign stat.cmd  = cmd_reg;
    assign stat.err  = err_reg;

endmodule

>>> hdl/iterative_int_add_sub_mul_div.sv
// Top level of the iterative integer add/subtract/multiply/divide unit.
// Instantiates iasmd_ctrl and iasmd_datapath; depends on iasmd_pkg.
//
//  Channel   Handshake                 Word
//  -------   -----------------------   ------------------------------------
//  command   start high, busy low      command, operand_a, operand_b
//  result    done high for one cycle   result_value, error_flag
//
// Iteration: add and subtract skip it; multiply runs one shift-add step
// per multiplier bit, divide one restoring step per quotient bit below
// the sign bit; a divide refused up front (zero divisor or a negative
// operand) skips it too, and a divide refused inside the loop (quotient
// bit beyond the divisor shift) stops after the step that finds it.
// Reset clears the controller only; the unit is idle right after reset.
// Busy rises once a command is accepted and stays high through the done
// cycle; the receiver cannot stall, and the result holds until reloaded.
module iterative_int_add_sub_mul_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               command,
    input  logic signed [iasmd_pkg::DATA_WIDTH-1:0] operand_a,
    input  logic signed [iasmd_pkg::DATA_WIDTH-1:0] operand_b,
    output logic                     done,
    output logic signed [iasmd_pkg::DATA_WIDTH-1:0] result_value,
    output logic                     error_flag
);
    import iasmd_pkg::*;

    dp_ctrl_t ctrl;
    dp_stat_t stat;
    word_t    result;

    // Sequence load, steps and the done strobe
    iasmd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy),
        .done  (done)
    );

    // Hold operands, iterate, and present the finished word
    iasmd_datapath u_datapath (
        .clk       (clk),
        .command   (cmd_t'(command)),
        .operand_a (word_t'(operand_a)),
        .operand_b (word_t'(operand_b)),
        .ctrl      (ctrl),
        .stat      (stat),
        .result    (result),
        .err       (error_flag)
    );

    assign result_value = result;

endmodule
